@@ src/xsip_pkg.sv @@
// Shared types and constants for the XML-skipping signed integer parser.
`timescale 1ns / 1ps

package xsip_pkg;

  localparam int unsigned NEST_BITS = 8;
  localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};
  localparam logic [NEST_BITS-1:0] NEST_ONE = {{(NEST_BITS-1){1'b0}}, 1'b1};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest accumulator that still takes a digit without overflow is
  // floor((limit - d) / 10); these are the values for small digits.
  localparam logic [63:0] ACC_LIM64 = 64'd922337203685477580;
  localparam logic [63:0] ACC_LIM32 = 64'd214748364;
  localparam logic [3:0]  DIG_POS_EDGE = 4'd7;
  localparam logic [3:0]  DIG_NEG_EDGE = 4'd8;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic STATUS_NUMBER    = 1'b0;
  localparam logic STATUS_EARLY_END = 1'b1;

  typedef enum logic [2:0] {
    PH_WS,
    PH_LT,
    PH_LT_BANG,
    PH_LT_BANG_DASH,
    PH_COMMENT,
    PH_CONSTRUCT,
    PH_SIGN,
    PH_DIGITS
  } phase_t;

  // A classified word as it travels from the front end to the back end.
  typedef struct packed {
    logic       at_end;
    logic [7:0] byte_val;
    logic       is_space;
    logic       is_lt;
    logic       is_gt;
    logic       is_dash;
    logic       is_plus;
    logic       is_quest;
    logic       is_bang;
    logic       is_digit;
    logic [3:0] digit;
  } entry_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               had_digits;
    logic               overflow;
    logic [7:0]         stop_byte;
    logic               stop_valid;
    logic [7:0]         held_byte;
    logic               held_valid;
    logic               status;
  } result_t;

endpackage

@@ src/xsip_front.sv @@
// Front end: classifies each accepted input word and pushes it to the queue.
`timescale 1ns / 1ps

module xsip_front (
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              in_stall,
  output logic              q_wr_en,
  output xsip_pkg::entry_t  q_wr_data
);

  logic [7:0] digit_off;

  assign in_stall  = q_full;
  assign q_wr_en   = in_valid & ~q_full;
  assign digit_off = in_data_byte - xsip_pkg::CH_ZERO;

  always_comb begin
    q_wr_data          = '0;
    q_wr_data.at_end   = (in_kind == xsip_pkg::KIND_END);
    q_wr_data.byte_val = in_data_byte;
    q_wr_data.is_space = (in_data_byte <= xsip_pkg::CH_SPACE);
    q_wr_data.is_lt    = (in_data_byte == xsip_pkg::CH_LT);
    q_wr_data.is_gt    = (in_data_byte == xsip_pkg::CH_GT);
    q_wr_data.is_dash  = (in_data_byte == xsip_pkg::CH_DASH);
    q_wr_data.is_plus  = (in_data_byte == xsip_pkg::CH_PLUS);
    q_wr_data.is_quest = (in_data_byte == xsip_pkg::CH_QUEST);
    q_wr_data.is_bang  = (in_data_byte == xsip_pkg::CH_BANG);
    q_wr_data.is_digit = (in_data_byte >= xsip_pkg::CH_ZERO) &&
                         (in_data_byte <= xsip_pkg::CH_NINE);
    q_wr_data.digit    = digit_off[3:0];
  end

endmodule

@@ src/xsip_queue.sv @@
// Two-entry queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module xsip_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  xsip_pkg::entry_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output xsip_pkg::entry_t  rd_data
);

  xsip_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/xsip_back.sv @@
// Back end: markup skip and number state machine with the result register.
`timescale 1ns / 1ps

module xsip_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              long_mode,
  input  logic              q_valid,
  input  xsip_pkg::entry_t  q_data,
  output logic              q_rd_en,
  output logic              out_valid,
  input  logic              out_stall,
  output xsip_pkg::result_t out_res
);

  xsip_pkg::phase_t state_r, state_nxt;
  logic [xsip_pkg::NEST_BITS-1:0] nest_r, nest_nxt, nest_dec;
  logic [1:0]  omc_r, omc_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r;
  xsip_pkg::result_t res_r;

  logic              take;
  logic              emit;
  logic              clear;
  xsip_pkg::result_t res;

  logic [63:0] acc_m, acc_lim, dig_acc;
  logic        dig_ovf;
  logic [3:0]  dig_edge;
  logic [31:0] val32;
  logic [63:0] val64, num_value;

  assign take      = q_valid & (~out_valid_r | ~out_stall);
  assign q_rd_en   = take;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Digit step: multiply by ten as two shifts and an add, in the selected width.
  always_comb begin
    acc_m    = long_mode ? acc_r : {32'b0, acc_r[31:0]};
    dig_edge = neg_r ? xsip_pkg::DIG_NEG_EDGE : xsip_pkg::DIG_POS_EDGE;
    acc_lim  = long_mode ? xsip_pkg::ACC_LIM64 : xsip_pkg::ACC_LIM32;
    if (q_data.digit > dig_edge) begin
      acc_lim = acc_lim - 64'd1;
    end
    dig_ovf = (acc_m > acc_lim);
    dig_acc = (acc_m << 3) + (acc_m << 1) + {60'b0, q_data.digit};
    if (!long_mode) begin
      dig_acc[63:32] = 32'b0;
    end
  end

  always_comb begin
    val32     = neg_r ? (32'd0 - acc_r[31:0]) : acc_r[31:0];
    val64     = neg_r ? (64'd0 - acc_r) : acc_r;
    num_value = long_mode ? val64 : {{32{val32[31]}}, val32};
    nest_dec  = (nest_r != '0) ? (nest_r - xsip_pkg::NEST_ONE) : nest_r;
  end

  always_comb begin
    state_nxt = state_r;
    nest_nxt  = nest_r;
    omc_nxt   = omc_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    clear     = 1'b0;
    res       = '0;
    res.value = num_value;
    res.overflow = ovf_r;

    if (take) begin
      unique case (state_r)
        xsip_pkg::PH_LT: begin
          if (q_data.at_end) begin
            emit           = 1'b1;
            res.stop_byte  = xsip_pkg::CH_LT;
            res.stop_valid = 1'b1;
          end else if (q_data.is_quest) begin
            nest_nxt  = {{(xsip_pkg::NEST_BITS-1){1'b0}}, 1'b1};
            state_nxt = xsip_pkg::PH_CONSTRUCT;
          end else if (q_data.is_bang) begin
            state_nxt = xsip_pkg::PH_LT_BANG;
          end else begin
            emit           = 1'b1;
            res.stop_byte  = xsip_pkg::CH_LT;
            res.stop_valid = 1'b1;
            res.held_byte  = q_data.byte_val;
            res.held_valid = 1'b1;
          end
        end
        xsip_pkg::PH_LT_BANG, xsip_pkg::PH_LT_BANG_DASH: begin
          if (q_data.at_end) begin
            emit = 1'b1;
            res  = '0;
            res.status = xsip_pkg::STATUS_EARLY_END;
          end else if (q_data.is_dash) begin
            state_nxt = (state_r == xsip_pkg::PH_LT_BANG) ?
                        xsip_pkg::PH_LT_BANG_DASH : xsip_pkg::PH_COMMENT;
            omc_nxt   = 2'd0;
          end else if (q_data.is_gt) begin
            // The broken opener already closes on this byte.
            nest_nxt  = '0;
            state_nxt = xsip_pkg::PH_WS;
          end else begin
            nest_nxt  = q_data.is_lt ? {{(xsip_pkg::NEST_BITS-2){1'b0}}, 2'b10}
                                     : {{(xsip_pkg::NEST_BITS-1){1'b0}}, 1'b1};
            state_nxt = xsip_pkg::PH_CONSTRUCT;
          end
        end
        xsip_pkg::PH_COMMENT: begin
          if (q_data.at_end) begin
            emit = 1'b1;
            res  = '0;
            res.status = xsip_pkg::STATUS_EARLY_END;
          end else if ((omc_r == 2'd2) && q_data.is_gt) begin
            omc_nxt   = 2'd0;
            state_nxt = xsip_pkg::PH_WS;
          end else if (q_data.is_dash) begin
            omc_nxt = (omc_r == 2'd2) ? omc_r : (omc_r + 2'd1);
          end else begin
            omc_nxt = 2'd0;
          end
        end
        xsip_pkg::PH_CONSTRUCT: begin
          if (q_data.at_end) begin
            emit = 1'b1;
            res  = '0;
            res.status = xsip_pkg::STATUS_EARLY_END;
          end else if (q_data.is_lt) begin
            if (nest_r != xsip_pkg::NEST_MAX) begin
              nest_nxt = nest_r + xsip_pkg::NEST_ONE;
            end
          end else if (q_data.is_gt) begin
            nest_nxt = nest_dec;
            if (nest_dec == '0) begin
              state_nxt = xsip_pkg::PH_WS;
            end
          end
        end
        xsip_pkg::PH_SIGN, xsip_pkg::PH_DIGITS: begin
          if (q_data.at_end) begin
            emit           = 1'b1;
            res.had_digits = (state_r == xsip_pkg::PH_DIGITS);
          end else if (q_data.is_digit) begin
            acc_nxt   = dig_acc;
            ovf_nxt   = ovf_r | dig_ovf;
            state_nxt = xsip_pkg::PH_DIGITS;
          end else begin
            emit           = 1'b1;
            res.had_digits = (state_r == xsip_pkg::PH_DIGITS);
            res.stop_byte  = q_data.byte_val;
            res.stop_valid = 1'b1;
          end
        end
        default: begin
          state_nxt = xsip_pkg::PH_WS;
          if (q_data.at_end) begin
            emit = 1'b1;
            res  = '0;
            res.status = xsip_pkg::STATUS_EARLY_END;
          end else if (q_data.is_space) begin
            state_nxt = xsip_pkg::PH_WS;
          end else if (q_data.is_lt) begin
            state_nxt = xsip_pkg::PH_LT;
          end else if (q_data.is_dash) begin
            neg_nxt   = 1'b1;
            state_nxt = xsip_pkg::PH_SIGN;
          end else if (q_data.is_plus) begin
            state_nxt = xsip_pkg::PH_SIGN;
          end else if (q_data.is_digit) begin
            acc_nxt   = dig_acc;
            ovf_nxt   = ovf_r | dig_ovf;
            state_nxt = xsip_pkg::PH_DIGITS;
          end else begin
            emit           = 1'b1;
            res.stop_byte  = q_data.byte_val;
            res.stop_valid = 1'b1;
          end
        end
      endcase
      clear = emit;
    end

    // Every result, good or bad, starts the next number from scratch.
    if (clear) begin
      state_nxt = xsip_pkg::PH_WS;
      nest_nxt  = '0;
      omc_nxt   = 2'd0;
      acc_nxt   = 64'd0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xsip_pkg::PH_WS;
      nest_r      <= '0;
      omc_r       <= 2'd0;
      acc_r       <= 64'd0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nest_r  <= nest_nxt;
      omc_r   <= omc_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

endmodule

@@ src/xml_skip_and_signed_int_parse.sv @@
// Top level of the XML-skipping signed decimal integer parser.
`timescale 1ns / 1ps

// Takes one text byte per word and returns one word per parsed number: leading
// whitespace, XML comments and <? / <! constructs are skipped, then an optional
// sign and decimal digits are read into a 32-bit or 64-bit value (cfg_data,
// 1 after reset). The block sustains one input word per clock while out_stall
// stays low. An accepted word lands in a two-entry queue; the parsing state
// machine consumes it from the queue head when the output is free to take a
// result, and at that edge also loads any result into the output register
// and raises out_valid; the per-byte limit is the single multiply-by-ten and
// compare step in the back end. While a finished result waits at a stalled
// output, input is still taken until the queue holds two words, then in_stall
// rises; a stalled output holds its result unchanged.
module xml_skip_and_signed_int_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_had_digits,
  output logic               out_overflow,
  output logic [7:0]         out_stop_byte,
  output logic               out_stop_valid,
  output logic [7:0]         out_held_byte,
  output logic               out_held_valid,
  output logic               out_status
);

  logic              long_mode_r;
  logic              q_wr_en;
  xsip_pkg::entry_t  q_wr_data;
  logic              q_full;
  logic              q_rd_en;
  logic              q_valid;
  xsip_pkg::entry_t  q_data;
  xsip_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b1;
    end else if (cfg_we) begin
      long_mode_r <= cfg_data;
    end
  end

  xsip_front u_front (
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .q_wr_en      (q_wr_en),
    .q_wr_data    (q_wr_data)
  );

  xsip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_rd_en),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  xsip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .long_mode (long_mode_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_rd_en   (q_rd_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_value      = res.value;
  assign out_had_digits = res.had_digits;
  assign out_overflow   = res.overflow;
  assign out_stop_byte  = res.stop_byte;
  assign out_stop_valid = res.stop_valid;
  assign out_held_byte  = res.held_byte;
  assign out_held_valid = res.held_valid;
  assign out_status     = res.status;

endmodule

@@ dv/xml_skip_and_signed_int_parse_test.sv @@
// Self-checking testbench for the XML-skipping signed integer parser with a byte-level predictor.
`timescale 1ns / 1ps

module xml_skip_and_signed_int_parse_test;

  localparam int   IDLE_PCT         = 36;
  localparam int   RANDOM_WORDS     = 260;
  localparam int   DRAIN_CYCLES     = 6;
  localparam int   CYCLE_LIMIT      = 400000;
  localparam int   DEEP_LEVELS      = 260;
  localparam int   MAX_REPORTS      = 10;
  localparam int   CFG_SPACING      = 80;
  localparam int   NO_GAP_FROM      = 100;
  localparam int   NO_GAP_TO        = 200;

  // Parses the byte stream the same way the block should and keeps the numbers still owed.
  class number_board;
    bit                             long_mode;
    xsip_pkg::phase_t               phase;
    logic [xsip_pkg::NEST_BITS-1:0] nest;
    logic [1:0]                     dash_run;
    logic [63:0]                    acc;
    bit                             neg;
    bit                             ovf;
    xsip_pkg::result_t              expected_numbers[$];
    int                             failures;

    function new();
      long_mode = 1'b1;
      failures = 0;
      clear_number();
    endfunction

    function void clear_number();
      phase = xsip_pkg::PH_WS;
      nest = '0;
      dash_run = '0;
      acc = '0;
      neg = 1'b0;
      ovf = 1'b0;
    endfunction

    function void set_mode(bit mode);
      long_mode = mode;
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    function logic [63:0] width_mask();
      return long_mode ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    endfunction

    function void add_digit(logic [3:0] d);
      logic [63:0] m;
      logic [63:0] lim;
      logic [63:0] a;
      m = width_mask();
      lim = (m >> 1) + {63'd0, neg};
      a = acc & m;
      if (!ovf && a > (lim - {60'd0, d}) / 64'd10) begin
        ovf = 1'b1;
      end
      acc = (a * 64'd10 + {60'd0, d}) & m;
    endfunction

    function void push_error();
      xsip_pkg::result_t r;
      r = '0;
      r.status = xsip_pkg::STATUS_EARLY_END;
      expected_numbers.push_back(r);
      clear_number();
    endfunction

    function void push_number(bit had, bit sv, logic [7:0] sb, bit hv, logic [7:0] hb);
      xsip_pkg::result_t r;
      logic [63:0]       m;
      logic [63:0]       v;
      m = width_mask();
      v = acc & m;
      if (neg) begin
        v = (64'd0 - v) & m;
      end
      if (!long_mode && v[31]) begin
        v[63:32] = '1;
      end
      r = '0;
      r.value = v;
      r.had_digits = had;
      r.overflow = ovf;
      r.stop_byte = sv ? sb : 8'h00;
      r.stop_valid = sv;
      r.held_byte = hv ? hb : 8'h00;
      r.held_valid = hv;
      r.status = xsip_pkg::STATUS_NUMBER;
      expected_numbers.push_back(r);
      clear_number();
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= xsip_pkg::CH_ZERO && b <= xsip_pkg::CH_NINE;
    endfunction

    function void construct_byte(logic [7:0] b);
      if (b == xsip_pkg::CH_LT) begin
        if (nest != xsip_pkg::NEST_MAX) begin
          nest++;
        end
      end else if (b == xsip_pkg::CH_GT) begin
        if (nest != '0) begin
          nest--;
        end
        if (nest == '0) begin
          phase = xsip_pkg::PH_WS;
        end
      end
    endfunction

    // Advances the parse by one accepted word; a finished number or error lands in the queue.
    function void take_byte(bit at_end, logic [7:0] b);
      case (phase)
        xsip_pkg::PH_LT: begin
          if (at_end) begin
            push_number(1'b0, 1'b1, xsip_pkg::CH_LT, 1'b0, 8'h00);
          end else if (b == xsip_pkg::CH_QUEST) begin
            nest = xsip_pkg::NEST_ONE;
            phase = xsip_pkg::PH_CONSTRUCT;
          end else if (b == xsip_pkg::CH_BANG) begin
            phase = xsip_pkg::PH_LT_BANG;
          end else begin
            push_number(1'b0, 1'b1, xsip_pkg::CH_LT, 1'b1, b);
          end
        end
        xsip_pkg::PH_LT_BANG, xsip_pkg::PH_LT_BANG_DASH: begin
          if (at_end) begin
            push_error();
          end else if (b == xsip_pkg::CH_DASH) begin
            if (phase == xsip_pkg::PH_LT_BANG) begin
              phase = xsip_pkg::PH_LT_BANG_DASH;
            end else begin
              dash_run = 2'd0;
              phase = xsip_pkg::PH_COMMENT;
            end
          end else begin
            // The byte that broke the comment opener already counts toward nesting.
            nest = xsip_pkg::NEST_ONE;
            phase = xsip_pkg::PH_CONSTRUCT;
            construct_byte(b);
          end
        end
        xsip_pkg::PH_COMMENT: begin
          if (at_end) begin
            push_error();
          end else if (dash_run >= 2'd2 && b == xsip_pkg::CH_GT) begin
            dash_run = 2'd0;
            phase = xsip_pkg::PH_WS;
          end else if (b == xsip_pkg::CH_DASH) begin
            if (dash_run < 2'd2) begin
              dash_run++;
            end
          end else begin
            dash_run = 2'd0;
          end
        end
        xsip_pkg::PH_CONSTRUCT: begin
          if (at_end) begin
            push_error();
          end else begin
            construct_byte(b);
          end
        end
        xsip_pkg::PH_SIGN: begin
          if (at_end) begin
            push_number(1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          end else if (is_digit(b)) begin
            add_digit(b[3:0]);
            phase = xsip_pkg::PH_DIGITS;
          end else begin
            push_number(1'b0, 1'b1, b, 1'b0, 8'h00);
          end
        end
        xsip_pkg::PH_DIGITS: begin
          if (at_end) begin
            push_number(1'b1, 1'b0, 8'h00, 1'b0, 8'h00);
          end else if (is_digit(b)) begin
            add_digit(b[3:0]);
          end else begin
            push_number(1'b1, 1'b1, b, 1'b0, 8'h00);
          end
        end
        default: begin
          phase = xsip_pkg::PH_WS;
          if (at_end) begin
            push_error();
          end else if (b > xsip_pkg::CH_SPACE) begin
            if (b == xsip_pkg::CH_LT) begin
              phase = xsip_pkg::PH_LT;
            end else if (b == xsip_pkg::CH_DASH) begin
              neg = 1'b1;
              phase = xsip_pkg::PH_SIGN;
            end else if (b == xsip_pkg::CH_PLUS) begin
              phase = xsip_pkg::PH_SIGN;
            end else if (is_digit(b)) begin
              add_digit(b[3:0]);
              phase = xsip_pkg::PH_DIGITS;
            end else begin
              push_number(1'b0, 1'b1, b, 1'b0, 8'h00);
            end
          end
        end
      endcase
    endfunction

    function void mismatch(string field, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("mismatch in %s: expected %h, got %h", field, want, got);
      end
    endfunction

    function void check_number(xsip_pkg::result_t got);
      xsip_pkg::result_t want;
      if (expected_numbers.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("result word with none expected: value %h status %b", got.value, got.status);
        end
        return;
      end
      want = expected_numbers.pop_front();
      if (got.value !== want.value) mismatch("value", want.value, got.value);
      if (got.had_digits !== want.had_digits)
        mismatch("had_digits", 64'(want.had_digits), 64'(got.had_digits));
      if (got.overflow !== want.overflow)
        mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
      if (got.stop_byte !== want.stop_byte)
        mismatch("stop_byte", 64'(want.stop_byte), 64'(got.stop_byte));
      if (got.stop_valid !== want.stop_valid)
        mismatch("stop_valid", 64'(want.stop_valid), 64'(got.stop_valid));
      if (got.held_byte !== want.held_byte)
        mismatch("held_byte", 64'(want.held_byte), 64'(got.held_byte));
      if (got.held_valid !== want.held_valid)
        mismatch("held_valid", 64'(want.held_valid), 64'(got.held_valid));
      if (got.status !== want.status)
        mismatch("status", 64'(want.status), 64'(got.status));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = xsip_pkg::KIND_DATA;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_value;
  logic               out_had_digits;
  logic               out_overflow;
  logic [7:0]         out_stop_byte;
  logic               out_stop_valid;
  logic [7:0]         out_held_byte;
  logic               out_held_valid;
  logic               out_status;

  number_board board;
  bit          gaps_on = 1'b1;
  int          words_sent = 0;
  int          cycle_count = 0;

  // Magnitudes at, just past and well past the 32-bit and 64-bit limits.
  string limit_texts [0:7] = '{"2147483647", "2147483648", "2147483649", "4294967296",
                               "9223372036854775807", "9223372036854775808",
                               "9223372036854775809", "99999999999999999999"};

  xml_skip_and_signed_int_parse uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_had_digits (out_had_digits),
    .out_overflow   (out_overflow),
    .out_stop_byte  (out_stop_byte),
    .out_stop_valid (out_stop_valid),
    .out_held_byte  (out_held_byte),
    .out_held_valid (out_held_valid),
    .out_status     (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : result_monitor
    xsip_pkg::result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.value = out_value;
      got.had_digits = out_had_digits;
      got.overflow = out_overflow;
      got.stop_byte = out_stop_byte;
      got.stop_valid = out_stop_valid;
      got.held_byte = out_held_byte;
      got.held_valid = out_held_valid;
      got.status = out_status;
      board.check_number(got);
    end
  end

  task automatic send_word(logic kind, logic [7:0] b);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      in_kind = 1'($urandom_range(1));
      in_data_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_data_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(kind, b);
    words_sent++;
  endtask

  task automatic send_end();
    send_word(xsip_pkg::KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(xsip_pkg::KIND_DATA, s[i]);
    end
  endtask

  // The parser may still hold a word that owes no result, so keep waiting past the drain.
  task automatic write_mode(bit mode);
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = mode;
    @(posedge clk);
    board.set_mode(mode);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b >= xsip_pkg::CH_ZERO && b <= xsip_pkg::CH_NINE);
    return b;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == xsip_pkg::CH_LT || b == xsip_pkg::CH_GT || b == xsip_pkg::CH_DASH);
    return b;
  endfunction

  task automatic send_number();
    int pick;
    repeat ($urandom_range(3))
      send_word(xsip_pkg::KIND_DATA, 8'($urandom_range(xsip_pkg::CH_SPACE)));
    pick = $urandom_range(2);
    if (pick == 1) begin
      send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_DASH);
    end else if (pick == 2) begin
      send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_PLUS);
    end
    if ($urandom_range(9) < 3) begin
      send_text(limit_texts[$urandom_range(7)]);
    end else begin
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 22 : 8))
        send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(9) < 2) begin
      send_end();
    end else begin
      send_word(xsip_pkg::KIND_DATA, non_digit());
    end
  endtask

  task automatic send_construct();
    int depth;
    int pick;
    depth = 1;
    if ($urandom_range(1)) begin
      send_text("<?");
    end else begin
      send_text("<!");
      send_word(xsip_pkg::KIND_DATA, 8'h41 + 8'($urandom_range(25)));
    end
    repeat ($urandom_range(10)) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_LT);
        depth++;
      end else if (pick == 1 && depth > 1) begin
        send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_GT);
        depth--;
      end else begin
        send_word(xsip_pkg::KIND_DATA, plain_byte());
      end
    end
    repeat (depth) send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_GT);
  endtask

  task automatic send_fragment();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_number();
    end else if (pick < 42) begin
      send_text("<!--");
      repeat ($urandom_range(8)) begin
        case ($urandom_range(3))
          0: send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_DASH);
          1: send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_GT);
          default: send_word(xsip_pkg::KIND_DATA, 8'($urandom_range(255)));
        endcase
      end
      send_text("-->");
    end else if (pick < 56) begin
      send_construct();
    end else if (pick < 66) begin
      send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_LT);
      if ($urandom_range(4) == 0) begin
        send_end();
      end else begin
        send_word(xsip_pkg::KIND_DATA, 8'($urandom_range(255)));
      end
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 6)) send_word(xsip_pkg::KIND_DATA, 8'($urandom_range(255)));
    end else if (pick < 84) begin
      send_end();
    end else if (pick < 93) begin
      // Comment openers that fall apart and turn into constructs.
      send_text("<!-");
      if ($urandom_range(1)) begin
        send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_LT);
        send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_GT);
      end else begin
        send_word(xsip_pkg::KIND_DATA, plain_byte());
      end
      send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_GT);
    end else begin
      case ($urandom_range(2))
        0: send_text("<!-- x");
        1: send_text("<?a<");
        default: send_text("<!-");
      endcase
      send_end();
    end
  endtask

  initial begin : stimulus
    int random_base;
    int next_cfg;
    int cfg_step;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(xsip_pkg::KIND_DATA, 8'h00);
    send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_SPACE);
    send_text("1");
    send_word(xsip_pkg::KIND_DATA, 8'hFF);
    send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_DASH);
    send_end();
    send_text("+a");
    send_end();
    send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_LT);
    send_word(xsip_pkg::KIND_DATA, 8'h00);
    send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_LT);
    send_end();
    send_text("<!-x>");
    send_text("<!---->");
    send_text("7");
    send_end();

    // Switch to 32-bit results while a number is half read.
    send_text("42");
    write_mode(1'b0);
    send_text("99999999999 ");

    // Nesting deep enough to saturate the level counter.
    send_text("<?");
    repeat (DEEP_LEVELS) send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_LT);
    repeat (DEEP_LEVELS) send_word(xsip_pkg::KIND_DATA, xsip_pkg::CH_GT);

    random_base = words_sent;
    next_cfg = CFG_SPACING;
    cfg_step = 0;
    while (words_sent - random_base < RANDOM_WORDS) begin
      gaps_on = !(words_sent - random_base >= NO_GAP_FROM &&
                  words_sent - random_base < NO_GAP_TO);
      if (words_sent - random_base >= next_cfg) begin
        write_mode(cfg_step == 0 ? 1'b1 : cfg_step == 1 ? 1'b0 : 1'($urandom_range(1)));
        cfg_step++;
        next_cfg += CFG_SPACING;
      end
      send_fragment();
    end
    gaps_on = 1'b1;

    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    board.failures += board.pending();
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
